### src/ttd_pkg.sv
package ttd_pkg;

  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned CordicStepsMax = 24;
  localparam int unsigned ZW = 34;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_TURN   = 2'd1,
    PH_DRIVE  = 2'd2,
    PH_ARRIVE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_CORDIC = 3'd1,
    ST_MUL    = 3'd2,
    ST_SQRT   = 3'd3,
    ST_DIV    = 3'd4,
    ST_OUT1   = 3'd5,
    ST_OUT2   = 3'd6
  } state_e;

  localparam logic [2:0] RegTargetX = 3'd0;
  localparam logic [2:0] RegTargetY = 3'd1;
  localparam logic [2:0] RegHeadGain = 3'd2;
  localparam logic [2:0] RegDistGain = 3'd3;
  localparam logic [2:0] RegHeadTol = 3'd4;
  localparam logic [2:0] RegDistTol = 3'd5;
  localparam logic [2:0] RegTurnLim = 3'd6;
  localparam logic [2:0] RegSpeedLim = 3'd7;

  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;

  function automatic logic [ZW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'h03243F6A8;
      5'd1: atan_q30 = 34'h01DAC6705;
      5'd2: atan_q30 = 34'h00FADBAFC;
      5'd3: atan_q30 = 34'h007F56EA6;
      5'd4: atan_q30 = 34'h003FEAB76;
      5'd5: atan_q30 = 34'h001FFD55B;
      5'd6: atan_q30 = 34'h000FFFAAA;
      5'd7: atan_q30 = 34'h0007FFF55;
      5'd8: atan_q30 = 34'h0003FFFEA;
      5'd9: atan_q30 = 34'h0001FFFFD;
      5'd10: atan_q30 = 34'h0000FFFFF;
      5'd11: atan_q30 = 34'h00007FFFF;
      5'd12: atan_q30 = 34'h00003FFFF;
      5'd13: atan_q30 = 34'h00001FFFF;
      5'd14: atan_q30 = 34'h00000FFFF;
      5'd15: atan_q30 = 34'h000007FFF;
      5'd16: atan_q30 = 34'h000003FFF;
      5'd17: atan_q30 = 34'h000001FFF;
      5'd18: atan_q30 = 34'h000000FFF;
      5'd19: atan_q30 = 34'h0000007FF;
      5'd20: atan_q30 = 34'h0000003FF;
      5'd21: atan_q30 = 34'h0000001FF;
      5'd22: atan_q30 = 34'h0000000FF;
      5'd23: atan_q30 = 34'h00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

### src/turn_then_drive_goal_controller.sv
// Turn-then-drive go-to-goal controller. Each accepted pose word yields zero, one or two
// result words on the master side, and a new pose word is taken only once every result of the
// previous one is out. A tick is accepted and then passes a setup step; a start tick then runs
// the serial atan2 rotator, a drive tick the bit-pair square root. Turn and drive ticks then
// run the shift-add gain multiplier and the restoring divide by 1536, and emit one result word
// at a time while the master side is ready. A tick in the arrived phase ends after setup with
// no result; stalls on the master side hold back the result words.
module turn_then_drive_goal_controller #(
  parameter int unsigned CORDIC_STEPS = ttd_pkg::CordicStepsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pose_x, pose_y, pose_heading
  input  logic [47:0] s_axis_tdata,
  // restart
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // turn_rate, forward_speed, zero pad
  output logic [31:0] m_axis_tdata,
  // phase_code
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned ZW = ttd_pkg::ZW;
  localparam int unsigned NS = (CORDIC_STEPS > ttd_pkg::CordicStepsMax) ?
                               ttd_pkg::CordicStepsMax : CORDIC_STEPS;

  logic signed [15:0] tx_q, ty_q;
  logic [15:0] hg_q, dg_q;
  logic [14:0] htol_q, dtol_q, tlim_q, slim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q <= '0; ty_q <= '0; hg_q <= 16'd3840; dg_q <= 16'd2560;
      htol_q <= 15'd41; dtol_q <= 15'd102; tlim_q <= 15'd4096; slim_q <= 15'd102;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttd_pkg::RegTargetX:  tx_q <= cfg_data_i;
        ttd_pkg::RegTargetY:  ty_q <= cfg_data_i;
        ttd_pkg::RegHeadGain: hg_q <= cfg_data_i;
        ttd_pkg::RegDistGain: dg_q <= cfg_data_i;
        ttd_pkg::RegHeadTol:  htol_q <= cfg_data_i[14:0];
        ttd_pkg::RegDistTol:  dtol_q <= cfg_data_i[14:0];
        ttd_pkg::RegTurnLim:  tlim_q <= cfg_data_i[14:0];
        ttd_pkg::RegSpeedLim: slim_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  ttd_pkg::state_e st_q, st_d;
  ttd_pkg::phase_e ph_q, ph_d;
  logic signed [15:0] goal_q, goal_d;
  logic signed [16:0] dx_q, dy_q, err_q;
  logic signed [15:0] hd_q;
  logic signed [ZW-1:0] cx_q, cy_q, cz_q;
  logic [5:0] cnt_q, cnt_d;
  // multiplier: acc holds product, mcand shifts left, mplier shifts right
  logic [34:0] acc_q, mc_q;
  logic [17:0] mp_q;
  // sqrt / divide
  logic [34:0] rem_q, quo_q, sv_q;
  logic neg_q, two_q, drv_q;
  logic [15:0] turn_q;
  logic [14:0] spd_q;

  logic [16:0] absdx, absdy;
  assign absdx = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
  assign absdy = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);

  // rotation index, one behind the counter after the preload cycle
  logic [4:0] ci;
  assign ci = cnt_q[4:0] - 5'd1;

  logic signed [ZW-1:0] sx, sy, za;
  assign sx = cx_q >>> ci;
  assign sy = cy_q >>> ci;
  assign za = $signed(ttd_pkg::atan_q30(ci));
  logic signed [ZW-1:0] zr;
  assign zr = (cz_q + ZW'(65536)) >>> 17;

  logic [16:0] aerr;
  assign aerr = err_q[16] ? 17'(-err_q) : 17'(err_q);

  // sqrt trial in rem_q (radicand bits shifted in via sv_q)
  logic [36:0] sq_rem, sq_trial;
  assign sq_rem = {rem_q, sv_q[33:32]};
  assign sq_trial = {quo_q[34:0], 2'b01};
  // divide trial
  logic [35:0] dv_rem;
  assign dv_rem = {rem_q, acc_q[34]};

  assign s_axis_tready = (st_q == ttd_pkg::ST_IDLE);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q + 6'd1;
    case (st_q)
      ttd_pkg::ST_IDLE: if (s_axis_tvalid) st_d = ttd_pkg::ST_CORDIC;
      ttd_pkg::ST_CORDIC: if (ph_q != ttd_pkg::PH_START || cnt_q == 6'(NS + 1)) begin
        st_d = (ph_q == ttd_pkg::PH_DRIVE) ? ttd_pkg::ST_SQRT :
               (ph_q == ttd_pkg::PH_ARRIVE) ? ttd_pkg::ST_IDLE : ttd_pkg::ST_MUL;
        cnt_d = '0;
      end
      ttd_pkg::ST_SQRT: if (cnt_q == 6'd16) begin st_d = ttd_pkg::ST_MUL; cnt_d = '0; end
      ttd_pkg::ST_MUL: if (cnt_q == 6'd17) begin st_d = ttd_pkg::ST_DIV; cnt_d = '0; end
      ttd_pkg::ST_DIV: if (cnt_q == 6'd34) begin st_d = ttd_pkg::ST_OUT1; cnt_d = '0; end
      ttd_pkg::ST_OUT1: if (m_axis_tready)
        st_d = two_q ? ttd_pkg::ST_OUT2 : ttd_pkg::ST_IDLE;
      ttd_pkg::ST_OUT2: if (m_axis_tready) st_d = ttd_pkg::ST_IDLE;
      default: st_d = ttd_pkg::ST_IDLE;
    endcase
    if (st_q == ttd_pkg::ST_IDLE) cnt_d = '0;
  end

  always_comb begin
    ph_d = ph_q; goal_d = goal_q;
    if (st_q == ttd_pkg::ST_IDLE && s_axis_tvalid && s_axis_tuser) ph_d = ttd_pkg::PH_START;
    if (st_q == ttd_pkg::ST_CORDIC && ph_q == ttd_pkg::PH_START && cnt_q == 6'(NS + 1)) begin
      ph_d = ttd_pkg::PH_TURN;
      if (dx_q == 0 && dy_q == 0) goal_d = '0;
      else if (zr > 32767) goal_d = 16'sd32767;
      else if (zr < -32768) goal_d = -16'sd32768;
      else goal_d = zr[15:0];
    end
    if (st_q == ttd_pkg::ST_DIV && cnt_q == 6'd34) begin
      if (ph_q == ttd_pkg::PH_TURN && aerr <= {2'b0, htol_q}) ph_d = ttd_pkg::PH_DRIVE;
      else if (ph_q == ttd_pkg::PH_DRIVE && sv_q[16:0] <= {2'b0, dtol_q})
        ph_d = ttd_pkg::PH_ARRIVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ttd_pkg::ST_IDLE; ph_q <= ttd_pkg::PH_START; goal_q <= '0; cnt_q <= '0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; goal_q <= goal_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ttd_pkg::ST_IDLE: if (s_axis_tvalid) begin
        dx_q <= 17'(tx_q) - 17'($signed(s_axis_tdata[15:0]));
        dy_q <= 17'(ty_q) - 17'($signed(s_axis_tdata[31:16]));
        hd_q <= s_axis_tdata[47:32];
        cx_q <= '0; cy_q <= '0; cz_q <= '0;
      end
      ttd_pkg::ST_CORDIC: begin
        if (cnt_q == 6'd0 && cx_q == 0 && cy_q == 0 && ph_q == ttd_pkg::PH_START
            && !drv_q) begin
          // preload: pre-rotate negative dx by pi
          if (dx_q[16]) begin
            cx_q <= -(ZW'(dx_q) <<< 14); cy_q <= -(ZW'(dy_q) <<< 14);
            cz_q <= dy_q[16] ? -ttd_pkg::PiQ30 : ttd_pkg::PiQ30;
          end else begin
            cx_q <= ZW'(dx_q) <<< 14; cy_q <= ZW'(dy_q) <<< 14; cz_q <= '0;
          end
        end else if (cnt_q != 6'(NS + 1)) begin
          if (!cy_q[ZW-1]) begin
            cx_q <= cx_q + sy; cy_q <= cy_q - sx; cz_q <= cz_q + za;
          end else begin
            cx_q <= cx_q - sy; cy_q <= cy_q + sx; cz_q <= cz_q - za;
          end
        end
        err_q <= 17'(goal_d) - 17'(hd_q);
        rem_q <= '0; quo_q <= '0;
        sv_q <= 35'({absdx} * {absdx}) + 35'({absdy} * {absdy});
      end
      ttd_pkg::ST_SQRT: begin
        if (sq_rem >= sq_trial) begin
          rem_q <= 35'(sq_rem - sq_trial); quo_q <= {quo_q[33:0], 1'b1};
        end else begin
          rem_q <= sq_rem[34:0]; quo_q <= {quo_q[33:0], 1'b0};
        end
        if (cnt_q == 6'd16) sv_q <= {quo_q[33:0], ~(sq_rem < sq_trial)};
        else sv_q <= sv_q << 2;
      end
      default: ;
    endcase
    if (st_q == ttd_pkg::ST_MUL) begin
      if (cnt_q == 6'd0) begin
        if (ph_q == ttd_pkg::PH_DRIVE) begin
          mc_q <= 35'(dg_q); mp_q <= 18'(sv_q[16:0]); neg_q <= 1'b0;
        end else begin
          mc_q <= 35'(hg_q); mp_q <= 18'(aerr); neg_q <= err_q[16];
        end
        acc_q <= '0;
      end else begin
        if (mp_q[0]) acc_q <= acc_q + mc_q;
        mc_q <= mc_q << 1; mp_q <= mp_q >> 1;
      end
      rem_q <= '0;
    end
    if (st_q == ttd_pkg::ST_DIV) begin
      if (cnt_q != 6'd34) begin
        if (dv_rem >= 36'd1536) begin
          rem_q <= 35'(dv_rem - 36'd1536); acc_q <= {acc_q[33:0], 1'b1};
        end else begin
          rem_q <= dv_rem[34:0]; acc_q <= {acc_q[33:0], 1'b0};
        end
      end else begin
        if (dv_rem >= 36'd1536) acc_q <= {acc_q[33:0], 1'b1};
        else acc_q <= {acc_q[33:0], 1'b0};
      end
    end
  end

  // result formation after division finishes
  logic [34:0] q_fin;
  assign q_fin = {acc_q[33:0], (dv_rem >= 36'd1536)};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_q <= 1'b0; drv_q <= 1'b0; turn_q <= '0; spd_q <= '0;
    end else begin
      if (st_q == ttd_pkg::ST_IDLE) drv_q <= 1'b0;
      if (st_q == ttd_pkg::ST_CORDIC) drv_q <= 1'b1;
      if (st_q == ttd_pkg::ST_DIV && cnt_q == 6'd34) begin
        if (ph_q == ttd_pkg::PH_TURN) begin
          two_q <= (aerr <= {2'b0, htol_q});
          spd_q <= '0;
          if (q_fin > 35'(tlim_q)) turn_q <= neg_q ? 16'(-{1'b0, tlim_q}) : {1'b0, tlim_q};
          else turn_q <= neg_q ? 16'(-q_fin[15:0]) : q_fin[15:0];
        end else begin
          two_q <= 1'b0; turn_q <= '0;
          spd_q <= (q_fin > 35'(slim_q)) ? slim_q : q_fin[14:0];
        end
      end
    end
  end

  logic [1:0] code1;
  assign code1 = two_q ? ttd_pkg::PH_TURN : ph_q;
  assign m_axis_tvalid = (st_q == ttd_pkg::ST_OUT1) || (st_q == ttd_pkg::ST_OUT2);
  assign m_axis_tdata = (st_q == ttd_pkg::ST_OUT2) ? 32'd0 : {1'b0, spd_q, turn_q};
  assign m_axis_tuser = (st_q == ttd_pkg::ST_OUT2) ? ph_q : code1;
  assign m_axis_tlast = (st_q == ttd_pkg::ST_OUT2) || !two_q;
endmodule
